// File: design/wmh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wake-up min-heap package
// Sizes, codes and transaction types shared by the wake-up min-heap modules.
// ----------------------------------------------------------------------------
package wmh_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned ID_BITS    = 8;
  localparam int unsigned ADDR_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_BITS = TIME_BITS + ID_BITS;

  localparam logic [TIME_BITS-1:0] EMPTY_TIME = '1;

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [ID_BITS-1:0]    task_id;
    logic [TIME_BITS-1:0]  wake_time;
  } wmh_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]    popped_id;
    logic [TIME_BITS-1:0]  popped_time;
    logic [ID_BITS-1:0]    head_id;
    logic [TIME_BITS-1:0]  head_time;
    logic [CNT_BITS-1:0]   entry_count;
    status_e               status;
  } wmh_rsp_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  key;
    logic [ID_BITS-1:0]    id;
  } wmh_entry_t;

endpackage
`default_nettype wire

// File: design/wakeup_min_heap_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wake-up min-heap
// Priority queue of sleeping tasks ordered by wake-up tick, held in a
// binary heap in on-chip memory, with a registered result stage.
// ----------------------------------------------------------------------------
// Each transaction is an insert or a remove of the earliest entry and yields
// exactly one result transaction with the popped entry, the new head, the
// entry count and a status. Requests are handled one at a time. An insert
// climbs the heap one level at a time until the new entry lands; a remove
// moves the last entry to the top and descends one level at a time. Each
// level is a step of the read-compare-write loop around the heap memory,
// whose read data is registered. Errors (insert when full, remove when
// empty), an insert into an empty heap and a remove of the last entry finish
// without a sift. A finished result waits in the output register while the
// next request is taken.
module wakeup_min_heap_top
  import wmh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wmh_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wmh_rsp_t out_rsp_o
);

  logic                 rsp_valid;
  logic                 rsp_ready;
  wmh_rsp_t             rsp;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  wmh_entry_t           wr_data;
  logic [ADDR_BITS-1:0] rd_addr_a, rd_addr_b;
  wmh_entry_t           rd_data_a, rd_data_b;
  logic                 out_valid_q;
  wmh_rsp_t             out_q;

  wmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_req_i),
    .req_stall_o (in_stall_o),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b)
  );

  wmh_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_busy_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> in_stall_o)
    else $error("Request taken while a result is still pending.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == STATUS_FULL))
      |-> (out_rsp_o.entry_count == CNT_BITS'(DEPTH)))
    else $error("Full status reported below capacity.");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.entry_count == '0))
      |-> (out_rsp_o.head_time == EMPTY_TIME) && (out_rsp_o.head_id == '0))
    else $error("Empty heap reports a head entry.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.entry_count <= CNT_BITS'(DEPTH)))
    else $error("Entry count exceeds capacity.");

endmodule
`default_nettype wire

// File: design/wmh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wake-up min-heap entry memory
// Synchronous memory with one write port and two read ports, read data
// registered, so reads return in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module wmh_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// File: design/wmh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wake-up min-heap sequencer
// Runs one request at a time: sift up after an insert and sift down after a
// remove, one heap level per cycle, reading the memory and writing back the
// moved entry. The entry being sifted is held in a register until it lands.
// ----------------------------------------------------------------------------
module wmh_ctrl
  import wmh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  wmh_req_t              req_i,
  output logic                  req_stall_o,
  output logic                  rsp_valid_o,
  output wmh_rsp_t              rsp_o,
  input  logic                  rsp_ready_i,
  output logic                  wr_en_o,
  output logic [ADDR_BITS-1:0]  wr_addr_o,
  output wmh_entry_t            wr_data_o,
  output logic [ADDR_BITS-1:0]  rd_addr_a_o,
  output logic [ADDR_BITS-1:0]  rd_addr_b_o,
  input  wmh_entry_t            rd_data_a_i,
  input  wmh_entry_t            rd_data_b_i
);

  localparam int unsigned CI_BITS = ADDR_BITS + 2;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP     = 3'd1;
  localparam logic [2:0] ST_UP_FIN = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_DOWN   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CNT_BITS-1:0]  count_q, count_d;
  wmh_entry_t           head_q, head_d;
  wmh_entry_t           x_q, x_d;
  wmh_entry_t           popped_q, popped_d;
  logic [ADDR_BITS-1:0] pos_q, pos_d;
  logic [ADDR_BITS-1:0] par_q, par_d;
  status_e              status_q, status_d;

  logic [ADDR_BITS-1:0] ins_pos;
  logic [CNT_BITS-1:0]  last_cnt;
  logic [CI_BITS-1:0]   l_cur, r_cur, cnt_ext;
  logic                 l_ok, r_ok, l_lt, r_lt_x, r_lt_l;
  logic                 go_left, go_right;
  logic [ADDR_BITS-1:0] child_pos;
  logic [ADDR_BITS:0]   nl_idx, nr_idx;

  assign ins_pos  = count_q[ADDR_BITS-1:0];
  assign last_cnt = count_q - CNT_BITS'(1);
  assign l_cur    = {1'b0, pos_q, 1'b1};
  assign r_cur    = l_cur + CI_BITS'(1);
  assign cnt_ext  = CI_BITS'(count_q);
  assign l_ok     = l_cur < cnt_ext;
  assign r_ok     = r_cur < cnt_ext;
  assign l_lt     = l_ok && (rd_data_a_i.key < x_q.key);
  assign r_lt_x   = r_ok && (rd_data_b_i.key < x_q.key);
  assign r_lt_l   = r_ok && (rd_data_b_i.key < rd_data_a_i.key);
  assign go_right = (l_lt && r_lt_l) || (!l_lt && r_lt_x);
  assign go_left  = l_lt && !r_lt_l;
  assign child_pos = go_right ? r_cur[ADDR_BITS-1:0] : l_cur[ADDR_BITS-1:0];
  assign nl_idx   = {child_pos, 1'b1};
  assign nr_idx   = nl_idx + (ADDR_BITS + 1)'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    x_d         = x_q;
    popped_d    = popped_q;
    pos_d       = pos_q;
    par_d       = par_q;
    status_d    = status_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = pos_q;
    wr_data_o   = x_q;
    rd_addr_a_o = par_q;
    rd_addr_b_o = nr_idx[ADDR_BITS-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          popped_d = '0;
          status_d = STATUS_OK;
          state_d  = ST_RESP;
          if (req_i.req_type == REQ_INSERT) begin
            if (count_q == CNT_BITS'(DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              x_d.key     = req_i.wake_time;
              x_d.id      = req_i.task_id;
              pos_d       = ins_pos;
              par_d       = (ins_pos - ADDR_BITS'(1)) >> 1;
              rd_addr_a_o = (ins_pos - ADDR_BITS'(1)) >> 1;
              count_d     = count_q + CNT_BITS'(1);
              if (count_q == '0) begin
                wr_en_o   = 1'b1;
                wr_addr_o = '0;
                wr_data_o = x_d;
              end else begin
                state_d = ST_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              popped_d = head_q;
              count_d  = last_cnt;
              if (last_cnt != '0) begin
                rd_addr_a_o = last_cnt[ADDR_BITS-1:0];
                state_d     = ST_LAST;
              end
            end
          end
        end
      end
      ST_UP: begin
        wr_en_o = 1'b1;
        if (x_q.key < rd_data_a_i.key) begin
          wr_data_o = rd_data_a_i;
          pos_d     = par_q;
          if (par_q == '0) begin
            state_d = ST_UP_FIN;
          end else begin
            par_d       = (par_q - ADDR_BITS'(1)) >> 1;
            rd_addr_a_o = (par_q - ADDR_BITS'(1)) >> 1;
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_UP_FIN: begin
        wr_en_o = 1'b1;
        state_d = ST_RESP;
      end
      ST_LAST: begin
        x_d         = rd_data_a_i;
        pos_d       = '0;
        rd_addr_a_o = ADDR_BITS'(1);
        rd_addr_b_o = ADDR_BITS'(2);
        state_d     = ST_DOWN;
      end
      ST_DOWN: begin
        wr_en_o     = 1'b1;
        rd_addr_a_o = nl_idx[ADDR_BITS-1:0];
        if (go_left) begin
          wr_data_o = rd_data_a_i;
          pos_d     = child_pos;
        end else if (go_right) begin
          wr_data_o = rd_data_b_i;
          pos_d     = child_pos;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wr_en_o && (wr_addr_o == '0)) begin
      head_d = wr_data_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    x_q      <= x_d;
    popped_q <= popped_d;
    pos_q    <= pos_d;
    par_q    <= par_d;
    status_q <= status_d;
  end

  assign req_stall_o = state_q != ST_IDLE;
  assign rsp_valid_o = state_q == ST_RESP;

  always_comb begin
    rsp_o.popped_id   = popped_q.id;
    rsp_o.popped_time = popped_q.key;
    rsp_o.entry_count = count_q;
    rsp_o.status      = status_q;
    if (count_q == '0) begin
      rsp_o.head_id   = '0;
      rsp_o.head_time = EMPTY_TIME;
    end else begin
      rsp_o.head_id   = head_q.id;
      rsp_o.head_time = head_q.key;
    end
  end

endmodule
`default_nettype wire

// File: sim/heap_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wake-up min-heap result checker
// Watches both channels of the wake-up min-heap. It keeps its own heap of
// (wake time, task id) entries, works out the result of every accepted
// request, and compares each accepted result, field by field, with the oldest
// result still awaited. It reports the failure count and some occupancy
// figures to the testbench top.
// ----------------------------------------------------------------------------
module heap_result_checker
  import wmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  wmh_req_t    in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  wmh_rsp_t    out_rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned full_hits_o,
  output int unsigned empty_hits_o,
  output int unsigned peak_fill_o
);

  logic [TIME_BITS-1:0] heap_key [DEPTH];
  logic [ID_BITS-1:0]   heap_id  [DEPTH];
  int unsigned          heap_fill  = 0;
  int unsigned          mismatches = 0;
  int unsigned          results    = 0;
  int unsigned          full_hits  = 0;
  int unsigned          empty_hits = 0;
  int unsigned          peak_fill  = 0;
  wmh_rsp_t             awaited_rsp [$];

  function automatic void exchange_slots(input int unsigned a, input int unsigned b);
    logic [TIME_BITS-1:0] k;
    logic [ID_BITS-1:0]   d;
    k           = heap_key[a];
    d           = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a]  = heap_id[b];
    heap_key[b] = k;
    heap_id[b]  = d;
  endfunction

  function automatic wmh_rsp_t heap_apply(input wmh_req_t req);
    wmh_rsp_t    rsp;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    logic        moving;
    rsp        = '0;
    rsp.status = STATUS_OK;
    if (req.req_type == REQ_INSERT) begin
      if (heap_fill >= DEPTH) begin
        rsp.status = STATUS_FULL;
        full_hits++;
      end else begin
        pos           = heap_fill;
        heap_key[pos] = req.wake_time;
        heap_id[pos]  = req.task_id;
        heap_fill++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_key[pos] < heap_key[up]) begin
            exchange_slots(pos, up);
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        rsp.status = STATUS_EMPTY;
        empty_hits++;
      end else begin
        rsp.popped_id   = heap_id[0];
        rsp.popped_time = heap_key[0];
        heap_fill--;
        heap_key[0] = heap_key[heap_fill];
        heap_id[0]  = heap_id[heap_fill];
        pos    = 0;
        moving = 1'b1;
        while (moving) begin
          best = pos;
          lc   = 2 * pos + 1;
          rc   = 2 * pos + 2;
          if (lc < heap_fill && heap_key[lc] < heap_key[best]) best = lc;
          if (rc < heap_fill && heap_key[rc] < heap_key[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            exchange_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    if (heap_fill > 0) begin
      rsp.head_id   = heap_id[0];
      rsp.head_time = heap_key[0];
    end else begin
      rsp.head_id   = '0;
      rsp.head_time = EMPTY_TIME;
    end
    rsp.entry_count = CNT_BITS'(heap_fill);
    return rsp;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("Result %0d: %s mismatch, expected %0h, actual %0h",
                 results, field, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    wmh_rsp_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (awaited_rsp.size() == 0) begin
          if (mismatches < 10) begin
            $display("Result %0d: transaction arrived with no request outstanding", results);
          end
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          report_field("popped_id", want.popped_id, out_rsp_i.popped_id);
          report_field("popped_time", want.popped_time, out_rsp_i.popped_time);
          report_field("head_id", want.head_id, out_rsp_i.head_id);
          report_field("head_time", want.head_time, out_rsp_i.head_time);
          report_field("entry_count", want.entry_count, out_rsp_i.entry_count);
          report_field("status", want.status, out_rsp_i.status);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_rsp.push_back(heap_apply(in_req_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_rsp.size();
    results_o    <= results;
    full_hits_o  <= full_hits;
    empty_hits_o <= empty_hits;
    peak_fill_o  <= peak_fill;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wake-up min-heap testbench
// Drives insert and remove transactions into the wake-up min-heap: a short
// directed run over empty, tied and extreme keys, then random phases that
// fill the heap past full, drain it past empty and mix both. Both sides idle
// at random, and the result side holds off for long stretches so that the
// block stalls its input. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import wmh_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  wmh_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  wmh_rsp_t    out_rsp;
  int unsigned fails;
  int unsigned pending;
  int unsigned results;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned peak_fill;
  logic        brisk = 1'b0;
  int unsigned sent  = 0;
  int unsigned level = 0;

  wakeup_min_heap_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  heap_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fails),
    .pending_o    (pending),
    .results_o    (results),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits),
    .peak_fill_o  (peak_fill)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned draw_gap();
    return brisk ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [TIME_BITS-1:0] draw_time();
    logic [TIME_BITS-1:0] t;
    case ($urandom_range(0, 5))
      0, 1: t = TIME_BITS'($urandom);
      2: t = TIME_BITS'($urandom_range(0, 7));
      3: t = $urandom_range(0, 1) ? EMPTY_TIME : '0;
      4: t = EMPTY_TIME - TIME_BITS'($urandom_range(0, 15));
      default: t = TIME_BITS'(1000 + $urandom_range(0, 3));
    endcase
    return t;
  endfunction

  task automatic send_req(input req_type_e kind, input logic [ID_BITS-1:0] id,
                          input logic [TIME_BITS-1:0] wake);
    wmh_req_t    req;
    int unsigned gap;
    req.req_type  = kind;
    req.task_id   = id;
    req.wake_time = wake;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    sent++;
    if (kind == REQ_INSERT) begin
      if (level < DEPTH) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  task automatic push_random();
    send_req(REQ_INSERT, ID_BITS'($urandom), draw_time());
  endtask

  task automatic pop_head();
    send_req(REQ_REMOVE, ID_BITS'($urandom), draw_time());
  endtask

  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    hold  = 0;
    taken = 0;
    out_stall <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        taken++;
        hold = (taken % 300 == 120) ? LONG_HOLD : draw_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[wakeup_min_heap_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned kind;
    int unsigned span;
    int unsigned bias;
    int unsigned target;
    in_valid <= 1'b0;
    in_req   <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    pop_head();
    send_req(REQ_INSERT, 8'h00, EMPTY_TIME);
    send_req(REQ_INSERT, 8'hFF, '0);
    send_req(REQ_INSERT, 8'h5A, TIME_BITS'(5));
    send_req(REQ_INSERT, 8'hA5, TIME_BITS'(5));
    send_req(REQ_INSERT, 8'h11, TIME_BITS'(5));
    send_req(REQ_INSERT, 8'h22, '0);
    send_req(REQ_INSERT, 8'h33, TIME_BITS'(32'h8000_0000));
    repeat (8) pop_head();
    send_req(REQ_INSERT, 8'h7F, TIME_BITS'(32'h7FFF_FFFF));
    send_req(REQ_INSERT, 8'h80, TIME_BITS'(32'h7FFF_FFFF));
    repeat (2) pop_head();

    target   = sent + RANDOM_ITEMS;
    phase_no = 0;
    while (sent < target) begin
      brisk = ($urandom_range(0, 3) == 0);
      kind  = (phase_no < 2) ? phase_no : $urandom_range(0, 3);
      case (kind)
        0: begin
          while (level < DEPTH) push_random();
          repeat ($urandom_range(1, 3)) push_random();
        end
        1: begin
          while (level > 0) pop_head();
          repeat ($urandom_range(1, 3)) pop_head();
        end
        default: begin
          span = $urandom_range(20, 60);
          bias = (kind == 2) ? 50 : 70;
          repeat (span) begin
            if ($urandom_range(0, 99) < bias) push_random();
            else pop_head();
          end
        end
      endcase
      phase_no++;
    end
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked results, peak occupancy %0d of %0d.",
             sent, results, peak_fill, DEPTH);
    $display("Inserts refused on a full heap: %0d, removes on an empty heap: %0d.",
             full_hits, empty_hits);
    if (fails == 0 && pending == 0) begin
      $display("[wakeup_min_heap_top] OK");
    end else begin
      $display("[wakeup_min_heap_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/wmh_pkg.sv
design/wmh_ram.sv
design/wmh_ctrl.sv
design/wakeup_min_heap_top.sv
sim/heap_result_checker.sv
sim/tb.sv
